// ===== rtl/core/u8u16_pkg.sv =====
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// Depends on nothing; the front end, queue, back end, top level and bench refer to it by scoped names.
package u8u16_pkg;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT_TAIL = 4'd1,
    ST_STRAY_CONT = 4'd2,
    ST_LEAD_LONG  = 4'd3,
    ST_BAD_BYTE2  = 4'd4,
    ST_BAD_BYTE3  = 4'd5,
    ST_BAD_BYTE4  = 4'd6,
    ST_SURROGATE  = 4'd7,
    ST_ABOVE_MAX  = 4'd8
  } status_e;

  // What the back end has to emit for one queued job
  typedef enum logic [1:0] {
    JOB_UNIT = 2'd0,  // one unit, value in low 16 bits
    JOB_PAIR = 2'd1,  // surrogate pair, value is code point minus 0x10000
    JOB_ERR  = 2'd2   // one error result
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [19:0] val;
    status_e     status;
  } job_t;

  localparam logic [20:0] SurrLo   = 21'h00D800;
  localparam logic [20:0] SurrHi   = 21'h00E000;
  localparam logic [20:0] SuppBase = 21'h010000;
  localparam logic [20:0] CpLimit  = 21'h110000;
  localparam logic [15:0] HiSurr   = 16'hD800;
  localparam logic [15:0] LoSurr   = 16'hDC00;

endpackage

// ===== rtl/core/u8u16_in_if.sv =====
// Input channel of the transcoder: one UTF-8 byte and the bytes left in the stream.
// Depends on nothing.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic [2:0] bytes_left;

  modport source (output valid, byte_in, bytes_left, input ready);
  modport sink   (input valid, byte_in, bytes_left, output ready);
endinterface

// ===== rtl/core/u8u16_out_if.sv =====
// Output channel of the transcoder: one UTF-16 unit with status and last flag.
// Depends on nothing.
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_out;
  logic [3:0]  status;
  logic        last_unit;

  modport source (output valid, unit_out, status, last_unit, input ready);
  modport sink   (input valid, unit_out, status, last_unit, output ready);
endinterface

// ===== rtl/core/u8u16_front.sv =====
// Front end: accepts UTF-8 bytes, tracks the open sequence and pushes jobs.
// Depends on u8u16_pkg and u8u16_in_if.
module u8u16_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8u16_in_if.sink          in_i,
  input  logic              full_i,
  output logic              push_o,
  output u8u16_pkg::job_t   job_o
);

  logic [2:0]  len_q, len_d;
  logic [1:0]  pos_q, pos_d;
  logic [20:0] cp_q, cp_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [2:0]  left_n;
  logic        stream_end;
  logic        err;
  u8u16_pkg::status_e err_st;
  logic [2:0]  lead_len;
  logic [20:0] lead_cp;
  logic [2:0]  need;
  logic [2:0]  rem;
  logic [20:0] cp_new;
  logic [2:0]  pos_inc;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    if (in_i.bytes_left == 3'd0) begin
      left_n = 3'd1;
    end else if (in_i.bytes_left > 3'd4) begin
      left_n = 3'd4;
    end else begin
      left_n = in_i.bytes_left;
    end
  end
  assign stream_end = (left_n == 3'd1);

  assign need    = len_q - {1'b0, pos_q};
  assign rem     = need - 3'd1;
  // one bit wider than the position so the fourth byte does not wrap
  assign pos_inc = {1'b0, pos_q} + 3'd1;

  always_comb begin
    case (rem)
      3'd1:    cp_new = cp_q | {9'b0, in_i.byte_in[5:0], 6'b0};
      3'd2:    cp_new = cp_q | {3'b0, in_i.byte_in[5:0], 12'b0};
      default: cp_new = cp_q | {15'b0, in_i.byte_in[5:0]};
    endcase
  end

  always_comb begin
    len_d    = len_q;
    pos_d    = pos_q;
    cp_d     = cp_q;
    halted_d = halted_q;
    push_o   = 1'b0;
    job_o    = '{kind: u8u16_pkg::JOB_UNIT, val: '0, status: u8u16_pkg::ST_OK};
    err      = 1'b0;
    err_st   = u8u16_pkg::ST_OK;
    lead_len = 3'd0;
    lead_cp  = '0;
    if (accept) begin
      if (halted_q) begin
        // drop bytes until the stream ends
        if (stream_end) halted_d = 1'b0;
      end else if (len_q == 3'd0) begin
        if (!in_i.byte_in[7]) begin
          push_o    = 1'b1;
          job_o.val = {12'b0, in_i.byte_in};
        end else if (in_i.byte_in[7:6] == 2'b10) begin
          err    = 1'b1;
          err_st = u8u16_pkg::ST_STRAY_CONT;
        end else begin
          if (in_i.byte_in[7:5] == 3'b110) begin
            lead_len = 3'd2;
            lead_cp  = {10'b0, in_i.byte_in[4:0], 6'b0};
          end else if (in_i.byte_in[7:4] == 4'b1110) begin
            lead_len = 3'd3;
            lead_cp  = {5'b0, in_i.byte_in[3:0], 12'b0};
          end else if (in_i.byte_in[7:3] == 5'b11110) begin
            lead_len = 3'd4;
            lead_cp  = {in_i.byte_in[2:0], 18'b0};
          end
          if (lead_len == 3'd0) begin
            err    = 1'b1;
            err_st = u8u16_pkg::ST_LEAD_LONG;
          end else if (left_n < lead_len) begin
            err    = 1'b1;
            err_st = u8u16_pkg::ST_SHORT_TAIL;
          end else begin
            len_d = lead_len;
            pos_d = 2'd1;
            cp_d  = lead_cp;
          end
        end
      end else begin
        if (left_n < need) begin
          err    = 1'b1;
          err_st = u8u16_pkg::ST_SHORT_TAIL;
        end else if (in_i.byte_in[7:6] != 2'b10) begin
          err = 1'b1;
          case (pos_q)
            2'd1:    err_st = u8u16_pkg::ST_BAD_BYTE2;
            2'd2:    err_st = u8u16_pkg::ST_BAD_BYTE3;
            default: err_st = u8u16_pkg::ST_BAD_BYTE4;
          endcase
        end else if (pos_inc >= len_q) begin
          // sequence complete: classify the code point
          len_d = 3'd0;
          pos_d = 2'd0;
          cp_d  = '0;
          if (cp_new >= u8u16_pkg::SurrLo && cp_new < u8u16_pkg::SurrHi) begin
            err    = 1'b1;
            err_st = u8u16_pkg::ST_SURROGATE;
          end else if (cp_new < u8u16_pkg::SuppBase) begin
            push_o    = 1'b1;
            job_o.val = {4'b0, cp_new[15:0]};
          end else if (cp_new >= u8u16_pkg::CpLimit) begin
            err    = 1'b1;
            err_st = u8u16_pkg::ST_ABOVE_MAX;
          end else begin
            push_o     = 1'b1;
            job_o.kind = u8u16_pkg::JOB_PAIR;
            job_o.val  = 20'(cp_new - u8u16_pkg::SuppBase);
          end
        end else begin
          pos_d = pos_inc[1:0];
          cp_d  = cp_new;
        end
      end
      if (err) begin
        len_d        = 3'd0;
        pos_d        = 2'd0;
        cp_d         = '0;
        halted_d     = !stream_end;
        push_o       = 1'b1;
        job_o.kind   = u8u16_pkg::JOB_ERR;
        job_o.val    = '0;
        job_o.status = err_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= 3'd0;
      pos_q    <= 2'd0;
      cp_q     <= '0;
      halted_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      pos_q    <= pos_d;
      cp_q     <= cp_d;
      halted_q <= halted_d;
    end
  end

  a_halt_no_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (len_q == 3'd0))
    else $error("halted with a sequence open");

  a_seq_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != 3'd0) |-> (pos_q != 2'd0 && {1'b0, pos_q} < len_q))
    else $error("sequence position out of range");

endmodule

// ===== rtl/core/u8u16_queue.sv =====
// Short job queue between front and back end of the transcoder.
// Depends on u8u16_pkg.
module u8u16_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8u16_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output u8u16_pkg::job_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  u8u16_pkg::job_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/u8u16_back.sv =====
// Back end: turns queued jobs into UTF-16 results through an output register.
// Depends on u8u16_pkg and u8u16_out_if.
module u8u16_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  u8u16_pkg::job_t head_i,
  output logic            pop_o,
  u8u16_out_if.source     out_o
);

  logic        valid_q, valid_d;
  logic [15:0] unit_q, unit_d;
  logic [3:0]  status_q, status_d;
  logic        last_q, last_d;
  logic        phase_q, phase_d;
  logic        advance;

  assign advance = !valid_q || out_o.ready;

  always_comb begin
    valid_d  = valid_q;
    unit_d   = unit_q;
    status_d = status_q;
    last_d   = last_q;
    phase_d  = phase_q;
    pop_o    = 1'b0;
    if (advance) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        status_d = u8u16_pkg::ST_OK;
        last_d   = 1'b1;
        pop_o    = 1'b1;
        unique case (head_i.kind)
          u8u16_pkg::JOB_PAIR: begin
            if (!phase_q) begin
              // high surrogate first, hold the job for the low half
              unit_d  = u8u16_pkg::HiSurr | {6'b0, head_i.val[19:10]};
              last_d  = 1'b0;
              phase_d = 1'b1;
              pop_o   = 1'b0;
            end else begin
              unit_d  = u8u16_pkg::LoSurr | {6'b0, head_i.val[9:0]};
              phase_d = 1'b0;
            end
          end
          u8u16_pkg::JOB_ERR: begin
            unit_d   = '0;
            status_d = head_i.status;
          end
          default: begin
            unit_d = head_i.val[15:0];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q   <= unit_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.unit_out  = unit_q;
  assign out_o.status    = status_q;
  assign out_o.last_unit = last_q;

  a_phase_on_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!empty_i && head_i.kind == u8u16_pkg::JOB_PAIR))
    else $error("low surrogate pending without a pair job");

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// Top level of the streaming UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if, u8u16_front, u8u16_queue, u8u16_back.
//
// Usage:
//   in_i carries one UTF-8 byte per transaction with the count of stream bytes
//   left (saturated at 4, 1 marks the stream's last byte). out_o carries
//   UTF-16 units with a status code and a flag on the last result of a byte.
//   A byte is taken every cycle while the job queue has room; a lead or middle
//   byte yields nothing, a final byte yields one unit, a surrogate pair (two
//   transactions on out_o) or, for the first error of a stream, one status
//   result. After an error, bytes are dropped until the stream's last byte.
//   Path: a byte is decoded and its first result's job written to the queue
//   at the accepting edge, then the job is loaded into the output register.
//   Throughput: one byte and one result per cycle while the queue has room and
//   out_o.ready stays high; the back end emits a pair's two units from one job.
//   Stalls: out_o.ready low holds the output register; the front end keeps
//   taking bytes until FifoDepth jobs wait, then drops in_i.ready.
//   Reset: asynchronous, clears the open sequence, the halt flag, the queue
//   and the output valid; the block is ready in the first cycle after it.
module utf8_to_utf16_transcoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8u16_in_if.sink     in_i,
  u8u16_out_if.source  out_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  u8u16_pkg::job_t job;
  u8u16_pkg::job_t head;

  // Decode bytes and track the open sequence
  u8u16_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  // Decouple decode from result delivery
  u8u16_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Expand jobs into units and hold them for the receiver
  u8u16_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== verif/tb_utf8_to_utf16_transcoder.sv =====
// Self-checking bench for utf8_to_utf16_transcoder: drives UTF-8 bytes, predicts UTF-16 units.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if and the transcoder RTL.
// A built-in decoder predicts every result; the monitor compares each one field by field.
module tb_utf8_to_utf16_transcoder;

  // Generous bound on the run: about 2000 bytes, each paying a sender gap and two results
  // that each wait out a receiver stall, taken several times over.
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned DecodeTarget = 1400;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned DrainCycles  = 20;

  typedef struct packed {
    logic [7:0] b;
    logic [2:0] left;
  } utf8_byte_t;

  typedef struct packed {
    logic [15:0]        code_unit;
    u8u16_pkg::status_e status;
    logic               is_last;
  } utf16_unit_t;

  logic clk_i;
  logic rst_ni;

  u8u16_in_if  in_bus ();
  u8u16_out_if out_bus ();

  utf8_to_utf16_transcoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Bytes waiting to be offered, and UTF-16 units the decoder says must come out.
  utf8_byte_t  pending_bytes[$];
  utf16_unit_t expected_units[$];
  logic [7:0]  stream_buf[$];

  // Decoder state, mirroring what the block keeps between bytes.
  logic [2:0]  open_len = '0;
  logic [2:0]  open_pos = '0;
  logic [20:0] open_cp  = '0;
  bit          dec_halted = 1'b0;

  int unsigned bytes_decoded = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  // Stimulus controls, written at the falling edge and read at the rising edge.
  bit idle_en   = 1'b1;
  bit sink_hold = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  int unsigned src_gap;
  int unsigned sink_gap;
  utf8_byte_t  nxt_item;
  utf16_unit_t want;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hold every block input at a known value from time zero, then release reset.
  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.byte_in    = '0;
    in_bus.bytes_left = 3'd1;
    out_bus.ready     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: end the run as failed if it overstays the cycle limit.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0d] MISMATCH: %s", cycle_count, what);
  endtask

  // ---------------------------------------------------------------------------
  // Decoder: work out the UTF-16 results of one accepted byte
  // ---------------------------------------------------------------------------
  function automatic void push_unit(input logic [15:0] u, input u8u16_pkg::status_e st,
                                    input logic lst);
    utf16_unit_t r;
    r.code_unit = u;
    r.status    = st;
    r.is_last   = lst;
    expected_units.push_back(r);
  endfunction

  // An error drops the open sequence and mutes the stream, unless this byte ends it.
  function automatic void raise_error(input u8u16_pkg::status_e st, input bit at_end);
    open_len   = '0;
    open_pos   = '0;
    open_cp    = '0;
    dec_halted = !at_end;
    push_unit(16'h0000, st, 1'b1);
  endfunction

  // A complete code point: one unit in the BMP, a surrogate pair above it.
  function automatic void emit_code_point(input logic [20:0] cp, input bit at_end);
    logic [20:0] off;
    open_len = '0;
    open_pos = '0;
    open_cp  = '0;
    if (cp >= u8u16_pkg::SurrLo && cp < u8u16_pkg::SurrHi) begin
      raise_error(u8u16_pkg::ST_SURROGATE, at_end);
    end else if (cp < u8u16_pkg::SuppBase) begin
      push_unit(cp[15:0], u8u16_pkg::ST_OK, 1'b1);
    end else if (cp >= u8u16_pkg::CpLimit) begin
      raise_error(u8u16_pkg::ST_ABOVE_MAX, at_end);
    end else begin
      off = cp - u8u16_pkg::SuppBase;
      push_unit(u8u16_pkg::HiSurr | {6'd0, off[19:10]}, u8u16_pkg::ST_OK, 1'b0);
      push_unit(u8u16_pkg::LoSurr | {6'd0, off[9:0]}, u8u16_pkg::ST_OK, 1'b1);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic [2:0] left_raw);
    int                 left;
    int                 need;
    int                 len;
    int                 shift;
    bit                 at_end;
    logic [20:0]        cp;
    u8u16_pkg::status_e bad_pos;
    // Out-of-range counts saturate: zero reads as stream end, five and up as four.
    left   = (left_raw == 3'd0) ? 1 : ((left_raw > 3'd4) ? 4 : int'(left_raw));
    at_end = (left == 1);
    if (dec_halted) begin
      if (at_end) dec_halted = 1'b0;
      return;
    end
    bytes_decoded++;
    if (open_len == 3'd0) begin
      len = 0;
      cp  = '0;
      if (!b[7]) begin
        push_unit({8'h00, b}, u8u16_pkg::ST_OK, 1'b1);
        return;
      end
      if (b[7:6] == 2'b10) begin
        raise_error(u8u16_pkg::ST_STRAY_CONT, at_end);
        return;
      end
      if (b[7:5] == 3'b110) begin
        len = 2;
        cp  = 21'(b[4:0]) << 6;
      end else if (b[7:4] == 4'b1110) begin
        len = 3;
        cp  = 21'(b[3:0]) << 12;
      end else if (b[7:3] == 5'b11110) begin
        len = 4;
        cp  = 21'(b[2:0]) << 18;
      end
      if (len == 0) raise_error(u8u16_pkg::ST_LEAD_LONG, at_end);
      else if (left < len) raise_error(u8u16_pkg::ST_SHORT_TAIL, at_end);
      else begin
        open_len = 3'(len);
        open_pos = 3'd1;
        open_cp  = cp;
      end
    end else begin
      // The short-tail check comes ahead of the continuation check.
      need = int'(open_len) - int'(open_pos);
      case (open_pos)
        3'd1:    bad_pos = u8u16_pkg::ST_BAD_BYTE2;
        3'd2:    bad_pos = u8u16_pkg::ST_BAD_BYTE3;
        default: bad_pos = u8u16_pkg::ST_BAD_BYTE4;
      endcase
      if (left < need) begin
        raise_error(u8u16_pkg::ST_SHORT_TAIL, at_end);
      end else if (b[7:6] != 2'b10) begin
        raise_error(bad_pos, at_end);
      end else begin
        shift    = 6 * (int'(open_len) - 1 - int'(open_pos));
        open_cp  = open_cp | (21'(b[5:0]) << shift);
        open_pos = open_pos + 3'd1;
        if (open_pos == open_len) emit_code_point(open_cp, at_end);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes, with random gaps while idling is enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      src_gap      <= 0;
    end else begin
      // Predict the results of a transaction the moment it is accepted.
      if (in_bus.valid && in_bus.ready) decode_byte(in_bus.byte_in, in_bus.bytes_left);
      // Hold an offered byte until the block takes it.
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (src_gap != 0) begin
          in_bus.valid <= 1'b0;
          src_gap      <= src_gap - 1;
        end else if (pending_bytes.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          in_bus.valid <= 1'b0;
          src_gap      <= $urandom_range(0, 15);
        end else begin
          nxt_item          = pending_bytes.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.byte_in    <= nxt_item.b;
          in_bus.bytes_left <= nxt_item.left;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every accepted unit against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      sink_gap      <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("unexpected unit %h status %0d last %b",
                                    out_bus.unit_out, out_bus.status, out_bus.last_unit));
        end else begin
          want = expected_units.pop_front();
          if (out_bus.unit_out !== want.code_unit)
            report_mismatch($sformatf("unit_out %h, want %h", out_bus.unit_out, want.code_unit));
          if (out_bus.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_bus.status, want.status));
          if (out_bus.last_unit !== want.is_last)
            report_mismatch($sformatf("last_unit %b, want %b", out_bus.last_unit, want.is_last));
        end
      end
      if (sink_hold) begin
        out_bus.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        out_bus.ready <= 1'b0;
        sink_gap      <= sink_gap - 1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        sink_gap      <= $urandom_range(0, 15);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering bytes.
  initial begin
    while (!hold_go) @(negedge clk_i);
    sink_hold = 1'b1;
    repeat (LongHold) @(negedge clk_i);
    sink_hold = 1'b0;
    hold_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic [2:0] left);
    utf8_byte_t item;
    item.b    = b;
    item.left = left;
    pending_bytes.push_back(item);
  endtask

  // Append one UTF-8 character with random payload bits; optionally break it.
  task automatic encode_char(input bit broken);
    int unsigned kind;
    int unsigned n_cont;
    int unsigned flaw;
    int unsigned bad_idx;
    logic [7:0]  lead;
    logic [7:0]  cont;
    kind = $urandom_range(0, 9);
    flaw = broken ? $urandom_range(0, 3) : 4;
    if (kind < 3) begin
      lead   = {1'b0, 7'($urandom)};
      n_cont = 0;
    end else if (kind < 5) begin
      lead   = {3'b110, 5'($urandom)};
      n_cont = 1;
    end else if (kind < 7) begin
      // Lead ED lands in the surrogate range half the time.
      lead   = ($urandom_range(0, 7) == 0) ? 8'hED : {4'b1110, 4'($urandom)};
      n_cont = 2;
    end else begin
      // Mostly planes up to 16; leads F5..F7 always overshoot.
      lead   = {5'b11110, ($urandom_range(0, 7) == 0) ? 3'($urandom)
                                                      : 3'($urandom_range(0, 4))};
      n_cont = 3;
    end
    bad_idx = $urandom_range(0, 2);
    case (flaw)
      0: if (n_cont != 0) n_cont = n_cont - 1;
      1: lead = 8'hF8 | 8'($urandom_range(0, 7));
      2: stream_buf.push_back({2'b10, 6'($urandom)});
      default: ;
    endcase
    stream_buf.push_back(lead);
    for (int unsigned i = 0; i < n_cont; i++) begin
      cont = {2'b10, 6'($urandom)};
      if (flaw == 3 && i == bad_idx) cont = 8'($urandom);
      stream_buf.push_back(cont);
    end
  endtask

  // Queue a stream of characters with its bytes-left count; noisy streams
  // carry broken characters and now and then a wrong count.
  task automatic queue_stream(input int unsigned n_chars, input bit noisy);
    int          rest;
    logic [2:0]  left;
    stream_buf.delete();
    for (int unsigned k = 0; k < n_chars; k++)
      encode_char(noisy && $urandom_range(0, 9) == 0);
    for (int i = 0; i < stream_buf.size(); i++) begin
      rest = stream_buf.size() - i;
      left = (rest >= 4) ? 3'd4 : 3'(rest);
      if (noisy && $urandom_range(0, 24) == 0) left = 3'($urandom);
      offer_byte(stream_buf[i], left);
    end
  endtask

  task automatic queue_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) offer_byte(8'($urandom), 3'($urandom));
  endtask

  task automatic wait_quiet();
    while (pending_bytes.size() != 0 || in_bus.valid || expected_units.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_streams(input int unsigned target);
    int unsigned pick;
    while (bytes_decoded < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) queue_noise($urandom_range(1, 12));
      else if (pick == 1) queue_stream($urandom_range(20, 40), 1'b1);
      else queue_stream($urandom_range(1, 6), pick < 6);
      while (pending_bytes.size() > 8) @(negedge clk_i);
    end
  endtask

  initial begin
    while (!rst_ni) @(negedge clk_i);

    // Directed: field extremes, every length, every error class but surrogate and above-maximum.
    offer_byte(8'h00, 3'd1);                                // NUL
    offer_byte(8'hFF, 3'd1);                                // lead too long on the last byte
    offer_byte(8'hC2, 3'd2); offer_byte(8'hA9, 3'd1);       // two-byte form
    offer_byte(8'hE2, 3'd3); offer_byte(8'h82, 3'd2);
    offer_byte(8'hAC, 3'd1);                                // three-byte form
    offer_byte(8'hF4, 3'd4); offer_byte(8'h8F, 3'd3);
    offer_byte(8'hBF, 3'd2); offer_byte(8'hBF, 3'd1);       // U+10FFFF as a pair
    offer_byte(8'h80, 3'd0);                                // stray continuation, count zero
    offer_byte(8'hC2, 3'd1);                                // lead with too short a tail
    offer_byte(8'hE2, 3'd3); offer_byte(8'h82, 3'd1);       // tail runs out mid-sequence
    offer_byte(8'hC2, 3'd7); offer_byte(8'h41, 3'd5);       // bad second byte, then muted
    offer_byte(8'h7F, 3'd0);                                // muted byte that ends the stream
    offer_byte(8'hE2, 3'd3); offer_byte(8'h82, 3'd2);
    offer_byte(8'h41, 3'd1);                                // bad third byte
    offer_byte(8'hF0, 3'd4); offer_byte(8'h9F, 3'd3);
    offer_byte(8'h98, 3'd2); offer_byte(8'h41, 3'd1);       // bad fourth byte

    // Let the block drain completely before going on.
    wait_quiet();
    repeat (8) @(negedge clk_i);

    // Hold the receiver off while a steady ASCII stream fills the block.
    idle_en = 1'b0;
    hold_go = 1'b1;
    for (int i = 40; i >= 1; i--)
      offer_byte({1'b0, 7'($urandom_range(32, 126))}, (i >= 4) ? 3'd4 : 3'(i));
    while (!hold_done) @(negedge clk_i);
    idle_en = 1'b1;

    // Random streams with idling on both sides, then a stretch with none.
    random_streams(DecodeTarget - 150);
    idle_en = 1'b0;
    random_streams(DecodeTarget);

    wait_quiet();
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_units.size() != 0)
      report_mismatch($sformatf("%0d units never arrived", expected_units.size()));

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
